// ----- rtl/core/crc_checked_frame_receiver_assert.svh -----
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define CCFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, reset included.
`define CCFR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- rtl/core/ccfr_pkg.sv -----
package ccfr_pkg;

  // Payload buffer geometry and field widths.
  localparam int MAX_PAYLOAD = 64;
  localparam int ADDR_W      = 6;
  localparam int LEN_W       = 7;
  localparam int CFG_IDX_W   = 3;

  // CRC-16 constants: seed, generator polynomial and top bit.
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_MSB  = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BCAST_ADDR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_MSG_ID = 3'd4;

  // Receive phases, one-hot.
  typedef enum logic [9:0] {
    PH_SYNC0  = 10'b00_0000_0001,
    PH_SYNC1  = 10'b00_0000_0010,
    PH_DEST   = 10'b00_0000_0100,
    PH_SRC    = 10'b00_0000_1000,
    PH_MSG    = 10'b00_0001_0000,
    PH_LEN    = 10'b00_0010_0000,
    PH_DATA   = 10'b00_0100_0000,
    PH_CRC_LO = 10'b00_1000_0000,
    PH_CRC_HI = 10'b01_0000_0000,
    PH_EMIT   = 10'b10_0000_0000
  } phase_t;

  // One byte of CRC-16, MSB first, no reflection.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_MSB) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/crc_checked_frame_receiver.sv -----
// Frame receiver with sync hunt and CRC-16 check.
// Input channel: one received bus byte per request on rx_byte, in_valid/in_stall.
// The block hunts for the two sync bytes, then takes destination, source,
// message id, length and payload, writing the payload into a 64-byte buffer,
// then the CRC-16 low byte and high byte. Outside the drain, bytes are taken
// at one per cycle. Output channel: out_valid/out_stall with one request per
// payload byte, or one request with has_data low for an empty frame; last
// marks the final one. Only frames with a good CRC addressed to this node or
// to broadcast emit. After the CRC high byte is taken, the first result passes
// through the drain phase, the buffer's registered read and the output
// register; an empty frame skips the buffer read. The buffer then drains one
// result per cycle; in_stall stays high while it drains. When the receiver
// stalls, the output register holds its result and the drain pauses; once
// the last result sits in the output register the block takes input bytes
// again. Configuration: cfg_valid/cfg_ready, always ready.
// Reset (rst, synchronous) returns to the sync hunt, clears the output and
// loads the register defaults; the buffer needs no clearing.
module crc_checked_frame_receiver (
  input  logic                            clk,
  input  logic                            rst,
  // Input byte channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ccfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      dest_address,
  output logic [7:0]                      source_address,
  output logic [7:0]                      message_id,
  output logic [ccfr_pkg::LEN_W-1:0]      payload_length,
  output logic [ccfr_pkg::ADDR_W-1:0]     byte_index,
  output logic [7:0]                      data_byte,
  output logic                            has_data,
  output logic                            is_broadcast,
  output logic                            reset_request,
  output logic                            last
);

  // Configuration registers.
  logic [7:0] sync_first;
  logic [7:0] sync_second;
  logic [7:0] node_address;
  logic [7:0] broadcast_address;
  logic [7:0] reset_msg_id;

  // Receive state.
  ccfr_pkg::phase_t               phase;
  logic [7:0]                     hdr_dest;
  logic [7:0]                     hdr_source;
  logic [7:0]                     hdr_msg;
  logic [ccfr_pkg::LEN_W-1:0]     hdr_length;
  logic [ccfr_pkg::LEN_W-1:0]     fill_count;
  logic [ccfr_pkg::LEN_W-1:0]     fill_count_next;
  logic [15:0]                    running_crc;
  logic [15:0]                    crc_update;
  logic [7:0]                     crc_low_byte;

  // Drain pipeline between buffer read and output register.
  logic                           pend;
  logic [ccfr_pkg::ADDR_W-1:0]    pend_idx;
  logic [ccfr_pkg::ADDR_W-1:0]    last_idx;
  logic [7:0]                     rd_data;

  logic in_accept;
  logic addr_match;
  logic crc_match;
  logic out_free;
  logic emitting;
  logic load;
  logic empty_load;
  logic last_load;
  logic issue;
  logic ram_we;

  assign cfg_ready = 1'b1;
  assign in_stall  = (phase == ccfr_pkg::PH_EMIT);
  assign in_accept = in_valid && !in_stall;

  assign crc_update      = ccfr_pkg::crc_byte(running_crc, rx_byte);
  assign fill_count_next = fill_count + ccfr_pkg::LEN_W'(1);
  assign addr_match      = (hdr_dest == node_address) || (hdr_dest == broadcast_address);
  assign crc_match       = ({rx_byte, crc_low_byte} == running_crc);

  // Drain control: a read is issued when the stage after it can move.
  assign emitting   = (phase == ccfr_pkg::PH_EMIT);
  assign out_free   = !out_valid || !out_stall;
  assign load       = pend && out_free;
  assign empty_load = emitting && (hdr_length == '0) && out_free;
  assign issue      = emitting && (hdr_length != '0) && (fill_count < hdr_length)
                      && (!pend || load);
  assign last_idx   = hdr_length[ccfr_pkg::ADDR_W-1:0] - ccfr_pkg::ADDR_W'(1);
  assign last_load  = load && (pend_idx == last_idx);

  assign ram_we = in_accept && (phase == ccfr_pkg::PH_DATA);

  // Payload buffer.
  ccfr_ram #(
    .WIDTH (8),
    .DEPTH (ccfr_pkg::MAX_PAYLOAD)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[ccfr_pkg::ADDR_W-1:0]),
    .wdata (rx_byte),
    .re    (issue),
    .raddr (fill_count[ccfr_pkg::ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Configuration register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first        <= 8'd0;
      sync_second       <= 8'd0;
      node_address      <= 8'd0;
      broadcast_address <= 8'd255;
      reset_msg_id      <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ccfr_pkg::REG_SYNC_FIRST:   sync_first        <= cfg_data;
        ccfr_pkg::REG_SYNC_SECOND:  sync_second       <= cfg_data;
        ccfr_pkg::REG_NODE_ADDR:    node_address      <= cfg_data;
        ccfr_pkg::REG_BCAST_ADDR:   broadcast_address <= cfg_data;
        ccfr_pkg::REG_RESET_MSG_ID: reset_msg_id      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame parser and drain sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ccfr_pkg::PH_SYNC0;
      hdr_dest     <= 8'd0;
      hdr_source   <= 8'd0;
      hdr_msg      <= 8'd0;
      hdr_length   <= '0;
      fill_count   <= '0;
      running_crc  <= ccfr_pkg::CRC_SEED;
      crc_low_byte <= 8'd0;
    end else if (emitting) begin
      // The buffer read walks fill_count; leave once the last result loads.
      if (issue) begin
        fill_count <= fill_count_next;
      end
      if (empty_load || last_load) begin
        phase      <= ccfr_pkg::PH_SYNC0;
        fill_count <= '0;
      end
    end else if (in_accept) begin
      unique case (phase)
        ccfr_pkg::PH_SYNC1: begin
          if (rx_byte == sync_second) begin
            phase       <= ccfr_pkg::PH_DEST;
            running_crc <= ccfr_pkg::CRC_SEED;
          end else begin
            phase <= ccfr_pkg::PH_SYNC0;
          end
        end
        ccfr_pkg::PH_DEST: begin
          hdr_dest    <= rx_byte;
          running_crc <= crc_update;
          phase       <= ccfr_pkg::PH_SRC;
        end
        ccfr_pkg::PH_SRC: begin
          hdr_source  <= rx_byte;
          running_crc <= crc_update;
          phase       <= ccfr_pkg::PH_MSG;
        end
        ccfr_pkg::PH_MSG: begin
          hdr_msg     <= rx_byte;
          running_crc <= crc_update;
          phase       <= ccfr_pkg::PH_LEN;
        end
        ccfr_pkg::PH_LEN: begin
          fill_count <= '0;
          if (rx_byte > 8'(ccfr_pkg::MAX_PAYLOAD)) begin
            // Oversized frame is dropped.
            phase        <= ccfr_pkg::PH_SYNC0;
            running_crc  <= ccfr_pkg::CRC_SEED;
            crc_low_byte <= 8'd0;
          end else begin
            hdr_length  <= rx_byte[ccfr_pkg::LEN_W-1:0];
            running_crc <= crc_update;
            phase       <= (rx_byte == 8'd0) ? ccfr_pkg::PH_CRC_LO : ccfr_pkg::PH_DATA;
          end
        end
        ccfr_pkg::PH_DATA: begin
          fill_count  <= fill_count_next;
          running_crc <= crc_update;
          if (fill_count_next >= hdr_length) begin
            phase <= ccfr_pkg::PH_CRC_LO;
          end
        end
        ccfr_pkg::PH_CRC_LO: begin
          crc_low_byte <= rx_byte;
          phase        <= ccfr_pkg::PH_CRC_HI;
        end
        ccfr_pkg::PH_CRC_HI: begin
          // Frame ends here; a good frame for us goes on to drain.
          fill_count   <= '0;
          running_crc  <= ccfr_pkg::CRC_SEED;
          crc_low_byte <= 8'd0;
          phase        <= (crc_match && addr_match) ? ccfr_pkg::PH_EMIT
                                                     : ccfr_pkg::PH_SYNC0;
        end
        default: begin
          // Hunting the first sync byte, and any phase with no meaning.
          phase <= (rx_byte == sync_first) ? ccfr_pkg::PH_SYNC1 : ccfr_pkg::PH_SYNC0;
        end
      endcase
    end
  end

  // Read data pending in the buffer's output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      pend_idx <= '0;
    end else if (issue) begin
      pend     <= 1'b1;
      pend_idx <= fill_count[ccfr_pkg::ADDR_W-1:0];
    end else if (load) begin
      pend <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load || empty_load) begin
      out_valid      <= 1'b1;
      dest_address   <= hdr_dest;
      source_address <= hdr_source;
      message_id     <= hdr_msg;
      payload_length <= hdr_length;
      byte_index     <= load ? pend_idx : '0;
      data_byte      <= load ? rd_data : 8'd0;
      has_data       <= load;
      is_broadcast   <= (hdr_dest == broadcast_address);
      reset_request  <= (hdr_msg == reset_msg_id);
      last           <= empty_load || last_load;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

`include "crc_checked_frame_receiver_assert.svh"

  `CCFR_ASSERT(a_pend_only_in_emit, pend |-> emitting, "buffer read pending outside the drain")
  `CCFR_ASSERT(a_fill_in_range, emitting |-> fill_count <= hdr_length, "drain read past frame length")
  `CCFR_ASSERT(a_pend_holds, pend && !load |=> pend && $stable(rd_data), "pending read data lost")
  `CCFR_ASSERT(a_one_load, !(load && empty_load), "payload and empty result loaded together")
  `CCFR_ASSERT_ALWAYS(a_reset_clear, rst |=> !out_valid && !pend, "reset left a result")

endmodule

// ----- rtl/core/ccfr_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module ccfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sim/tb.sv -----
module tb;

  // Kinds of damage a generated frame can carry.
  localparam int FLAW_NONE      = 0;
  localparam int FLAW_BAD_CRC   = 1;
  localparam int FLAW_OVERSIZE  = 2;
  localparam int FLAW_TRUNCATED = 3;

  // Receiver stall patterns.
  localparam int STALL_NONE    = 0;
  localparam int STALL_RANDOM  = 1;
  localparam int STALL_PATTERN = 2;
  localparam int STALL_HEAVY   = 3;

  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_PAUSE    = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  // One result request as seen on the output channel.
  typedef struct packed {
    logic [7:0]                  dest;
    logic [7:0]                  src;
    logic [7:0]                  msg;
    logic [ccfr_pkg::LEN_W-1:0]  len;
    logic [ccfr_pkg::ADDR_W-1:0] idx;
    logic [7:0]                  data;
    logic                        has_data;
    logic                        bcast;
    logic                        rst_req;
    logic                        fin;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [7:0]                     rx_byte = 8'h00;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [ccfr_pkg::CFG_IDX_W-1:0] cfg_index = ccfr_pkg::REG_SYNC_FIRST;
  logic [7:0]                     cfg_data = 8'h00;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [7:0]                     dest_address;
  logic [7:0]                     source_address;
  logic [7:0]                     message_id;
  logic [ccfr_pkg::LEN_W-1:0]     payload_length;
  logic [ccfr_pkg::ADDR_W-1:0]    byte_index;
  logic [7:0]                     data_byte;
  logic                           has_data;
  logic                           is_broadcast;
  logic                           reset_request;
  logic                           last;

  crc_checked_frame_receiver DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .dest_address   (dest_address),
    .source_address (source_address),
    .message_id     (message_id),
    .payload_length (payload_length),
    .byte_index     (byte_index),
    .data_byte      (data_byte),
    .has_data       (has_data),
    .is_broadcast   (is_broadcast),
    .reset_request  (reset_request),
    .last           (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected register contents, tracked as they are written.
  logic [7:0] exp_sync_first  = 8'h00;
  logic [7:0] exp_sync_second = 8'h00;
  logic [7:0] exp_node        = 8'h00;
  logic [7:0] exp_bcast       = 8'hFF;
  logic [7:0] exp_reset_id    = 8'h00;

  // Receiver state as predicted from the accepted bytes.
  ccfr_pkg::phase_t           frame_phase = ccfr_pkg::PH_SYNC0;
  logic [7:0]                 seen_dest   = 8'h00;
  logic [7:0]                 seen_src    = 8'h00;
  logic [7:0]                 seen_msg    = 8'h00;
  logic [ccfr_pkg::LEN_W-1:0] seen_len    = '0;
  logic [ccfr_pkg::LEN_W-1:0] seen_count  = '0;
  logic [15:0]                crc_acc     = ccfr_pkg::CRC_SEED;
  logic [7:0]                 crc_lo_seen = 8'h00;
  logic [7:0]                 payload_buf [ccfr_pkg::MAX_PAYLOAD];

  frame_result_t results_due[$];
  logic [7:0]    bus_bytes[$];
  int            bytes_queued = 0;
  int            bytes_taken  = 0;
  int            failures     = 0;

  // Traffic shaping, set per phase by the stimulus.
  bit sender_gappy = 1'b0;
  int stall_mode   = STALL_NONE;
  bit hold_wanted  = 1'b0;

  // CRC-16, polynomial 0x1021, fed one data bit at a time, MSB first.
  function automatic logic [15:0] ccitt_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? ccfr_pkg::CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic restart_hunt();
    frame_phase = ccfr_pkg::PH_SYNC0;
    seen_count  = '0;
    crc_acc     = ccfr_pkg::CRC_SEED;
    crc_lo_seen = 8'h00;
  endtask

  // Advance the predicted receiver by one byte and queue any frame it releases.
  task automatic absorb_byte(input logic [7:0] b);
    frame_result_t r;
    int            n;
    case (frame_phase)
      ccfr_pkg::PH_SYNC1: begin
        if (b == exp_sync_second) begin
          frame_phase = ccfr_pkg::PH_DEST;
          crc_acc = ccfr_pkg::CRC_SEED;
        end else begin
          frame_phase = ccfr_pkg::PH_SYNC0;
        end
      end
      ccfr_pkg::PH_DEST: begin
        seen_dest = b;
        crc_acc = ccitt_update(crc_acc, b);
        frame_phase = ccfr_pkg::PH_SRC;
      end
      ccfr_pkg::PH_SRC: begin
        seen_src = b;
        crc_acc = ccitt_update(crc_acc, b);
        frame_phase = ccfr_pkg::PH_MSG;
      end
      ccfr_pkg::PH_MSG: begin
        seen_msg = b;
        crc_acc = ccitt_update(crc_acc, b);
        frame_phase = ccfr_pkg::PH_LEN;
      end
      ccfr_pkg::PH_LEN: begin
        crc_acc = ccitt_update(crc_acc, b);
        seen_count = '0;
        if (b > ccfr_pkg::MAX_PAYLOAD) begin
          restart_hunt();
        end else begin
          seen_len = b[ccfr_pkg::LEN_W-1:0];
          frame_phase = (b == 8'h00) ? ccfr_pkg::PH_CRC_LO : ccfr_pkg::PH_DATA;
        end
      end
      ccfr_pkg::PH_DATA: begin
        payload_buf[seen_count[ccfr_pkg::ADDR_W-1:0]] = b;
        seen_count = seen_count + ccfr_pkg::LEN_W'(1);
        crc_acc = ccitt_update(crc_acc, b);
        if (seen_count >= seen_len) frame_phase = ccfr_pkg::PH_CRC_LO;
      end
      ccfr_pkg::PH_CRC_LO: begin
        crc_lo_seen = b;
        frame_phase = ccfr_pkg::PH_CRC_HI;
      end
      ccfr_pkg::PH_CRC_HI: begin
        if ({b, crc_lo_seen} == crc_acc &&
            (seen_dest == exp_node || seen_dest == exp_bcast)) begin
          n = (seen_len == 0) ? 1 : int'(seen_len);
          for (int k = 0; k < n; k++) begin
            r.dest     = seen_dest;
            r.src      = seen_src;
            r.msg      = seen_msg;
            r.len      = seen_len;
            r.idx      = (seen_len == 0) ? '0 : k[ccfr_pkg::ADDR_W-1:0];
            r.data     = (seen_len == 0) ? 8'h00 : payload_buf[k];
            r.has_data = (seen_len != 0);
            r.bcast    = (seen_dest == exp_bcast);
            r.rst_req  = (seen_msg == exp_reset_id);
            r.fin      = (k == n - 1);
            results_due.push_back(r);
          end
        end
        restart_hunt();
      end
      default: begin
        frame_phase = (b == exp_sync_first) ? ccfr_pkg::PH_SYNC1 : ccfr_pkg::PH_SYNC0;
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [7:0] got,
                                      input logic [7:0] want);
    if (got !== want) begin
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("Mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endfunction

  // Monitor: checks result requests and feeds accepted bytes to the predictor.
  bit byte_taken = 1'b0;

  always @(posedge clk) begin : monitor
    frame_result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("Unexpected result: dest %0h index %0h data %0h",
                     dest_address, byte_index, data_byte);
        end else begin
          want = results_due.pop_front();
          check_field("dest_address", dest_address, want.dest);
          check_field("source_address", source_address, want.src);
          check_field("message_id", message_id, want.msg);
          check_field("payload_length", 8'(payload_length), 8'(want.len));
          check_field("byte_index", 8'(byte_index), 8'(want.idx));
          check_field("data_byte", data_byte, want.data);
          check_field("has_data", 8'(has_data), 8'(want.has_data));
          check_field("is_broadcast", 8'(is_broadcast), 8'(want.bcast));
          check_field("reset_request", 8'(reset_request), 8'(want.rst_req));
          check_field("last", 8'(last), 8'(want.fin));
        end
      end
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        absorb_byte(rx_byte);
        bytes_taken++;
      end
    end
  end

  // Driver: offers queued bytes in bursts, holding each one until it is taken.
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !byte_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (bus_bytes.size() > 0) begin
        rx_byte  <= bus_bytes.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = sender_gappy ? $urandom_range(1, 5) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off when requested.
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  stall_tick = 0;

  always @(negedge clk) begin
    stall_tick++;
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_wanted && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM:  out_stall <= ($urandom_range(0, 2) == 0);
        STALL_PATTERN: out_stall <= ((stall_tick % 7) >= 4);
        STALL_HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
        default:       out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: ends the run when no request of any kind moves for too long.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    bus_bytes.push_back(b);
    bytes_queued++;
  endtask

  // Builds a frame under the current sync bytes, with the CRC it should carry.
  task automatic queue_frame(input logic [7:0] dest, input logic [7:0] src,
                             input logic [7:0] msg, input int len, input int flaw);
    logic [7:0]  body[$];
    logic [15:0] crc;
    int          keep;
    body.push_back(dest);
    body.push_back(src);
    body.push_back(msg);
    body.push_back(len[7:0]);
    if (len <= ccfr_pkg::MAX_PAYLOAD)
      repeat (len) body.push_back(8'($urandom_range(0, 255)));
    crc = ccfr_pkg::CRC_SEED;
    foreach (body[i]) crc = ccitt_update(crc, body[i]);
    if (flaw == FLAW_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    keep = (flaw == FLAW_TRUNCATED) ? 4 + len / 2 : body.size();
    queue_byte(exp_sync_first);
    queue_byte(exp_sync_second);
    for (int i = 0; i < keep; i++) queue_byte(body[i]);
    if (flaw == FLAW_NONE || flaw == FLAW_BAD_CRC) begin
      queue_byte(crc[7:0]);
      queue_byte(crc[15:8]);
    end
  endtask

  // Mostly well-formed frames with random content, plus damaged ones and noise.
  task automatic queue_random_traffic(input int byte_budget);
    int         start;
    int         pick;
    int         len;
    logic [7:0] dest;
    logic [7:0] msg;
    logic [7:0] wrong;
    start = bytes_queued;
    while (bytes_queued - start < byte_budget) begin
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, ccfr_pkg::MAX_PAYLOAD)
                                         : $urandom_range(0, 6);
      dest = $urandom_range(0, 1) ? exp_node : exp_bcast;
      msg  = ($urandom_range(0, 3) == 0) ? exp_reset_id : 8'($urandom_range(0, 255));
      if (pick < 70) begin
        queue_frame(dest, 8'($urandom_range(0, 255)), msg, len, FLAW_NONE);
      end else if (pick < 78) begin
        queue_frame(dest, 8'($urandom_range(0, 255)), msg, len, FLAW_BAD_CRC);
      end else if (pick < 84) begin
        // Destination that is most likely neither ours nor broadcast.
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), msg, len,
                    FLAW_NONE);
      end else if (pick < 89) begin
        queue_frame(dest, 8'($urandom_range(0, 255)), msg, $urandom_range(65, 255),
                    FLAW_OVERSIZE);
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 5)) queue_byte(8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        // A failed second sync byte, then a good frame right behind it.
        wrong = (exp_sync_first != exp_sync_second) ? exp_sync_first : ~exp_sync_second;
        queue_byte(exp_sync_first);
        queue_byte(wrong);
        queue_frame(dest, 8'($urandom_range(0, 255)), msg, len, FLAW_NONE);
      end else begin
        queue_frame(dest, 8'($urandom_range(0, 255)), msg, $urandom_range(2, 8),
                    FLAW_TRUNCATED);
      end
    end
  endtask

  task automatic write_reg(input logic [ccfr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Writes every register; the block must be idle.
  task automatic program_node(input logic [7:0] sf, input logic [7:0] ss,
                              input logic [7:0] node, input logic [7:0] bc,
                              input logic [7:0] rid);
    write_reg(ccfr_pkg::REG_SYNC_FIRST, sf);
    exp_sync_first = sf;
    write_reg(ccfr_pkg::REG_SYNC_SECOND, ss);
    exp_sync_second = ss;
    write_reg(ccfr_pkg::REG_NODE_ADDR, node);
    exp_node = node;
    write_reg(ccfr_pkg::REG_BCAST_ADDR, bc);
    exp_bcast = bc;
    write_reg(ccfr_pkg::REG_RESET_MSG_ID, rid);
    exp_reset_id = rid;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every byte is taken and every result has come, then lets
  // the block finish any frame that produced nothing.
  task automatic settle();
    while (bytes_taken != bytes_queued || results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults under heavy receiver stalls: an empty frame to us
    // with the reset message id, and an oversize length.
    stall_mode = STALL_HEAVY;
    queue_frame(8'h00, 8'hFF, 8'h00, 0, FLAW_NONE);
    queue_frame(8'hFF, 8'h00, 8'h00, ccfr_pkg::MAX_PAYLOAD + 1, FLAW_OVERSIZE);
    settle();

    // Extreme register values, a repeated first sync byte, a bad CRC and a
    // foreign destination.
    program_node(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_frame(8'h00, 8'h7F, 8'hFF, 1, FLAW_NONE);
    queue_frame(8'hFF, 8'h01, 8'h00, 0, FLAW_BAD_CRC);
    queue_frame(8'h42, 8'h01, 8'h00, 0, FLAW_NONE);
    sender_gappy = 1'b1;
    stall_mode   = STALL_RANDOM;
    settle();

    // Long receiver hold-off while the sender keeps offering bytes, with a
    // frame of the largest payload followed by random traffic.
    program_node(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    sender_gappy = 1'b0;
    stall_mode   = STALL_PATTERN;
    queue_frame(exp_node, 8'h22, 8'h33, ccfr_pkg::MAX_PAYLOAD, FLAW_NONE);
    queue_random_traffic(8);
    hold_wanted = 1'b1;
    settle();

    failures += results_due.size();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
